// ===== rtl/bcfpb_pkg.sv =====
package bcfpb_pkg;

  // Address operand length in bytes (1 to 4); the chain keeps 24 bits.
  localparam int ADDRESS_BYTES = 3;
  localparam int ADDR_W        = 24;
  localparam int CNT_W         = (ADDRESS_BYTES > 1) ? $clog2(ADDRESS_BYTES) : 1;

  localparam logic [CNT_W-1:0] ADDR_LAST = CNT_W'(ADDRESS_BYTES - 1);

  // Command bytes seen while idle
  localparam logic [7:0] OPC_INIT    = 8'h01;
  localparam logic [7:0] OPC_STATUS  = 8'h02;
  localparam logic [7:0] OPC_RESET   = 8'h04;
  localparam logic [7:0] OPC_MODE    = 8'h08;
  localparam logic [7:0] OPC_READY   = 8'h10;
  localparam logic [7:0] OPC_ADDRESS = 8'hAD;
  localparam logic [7:0] OPC_WRITE   = 8'hDA;
  localparam logic [7:0] OPC_READ    = 8'hDB;

  localparam logic [7:0] REPLY_ACK  = 8'hFE;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MODE,
    PH_DATAWR,
    PH_ADDR
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [CNT_W-1:0]   addr_cnt;
    logic [ADDR_W-1:0]  chain;
    logic [ADDR_W-1:0]  latch;
    logic [2:0]         pins;       // bit 0 WE, bit 1 CE, bit 2 OE
    logic               indicator;
    logic [7:0]         bus_value;
    logic               bus_driven;
  } state_t;

  typedef struct packed {
    logic               tx_valid;
    logic [7:0]         tx_byte;
    logic               write_enable_pin;
    logic               chip_enable_pin;
    logic               output_enable_pin;
    logic               test_pin;
    logic               reset_pulse;
    logic [ADDR_W-1:0]  latched_address;
    logic [7:0]         data_out;
    logic               data_drive;
  } result_t;

endpackage

// ===== rtl/byte_command_flash_pin_bridge.sv =====
// Byte command bridge between a host serial link and parallel flash pins.
//
// Input channel (in_valid/in_ready): one beat per received host byte, with
// the sampled flash busy line and the value on the flash data bus. Idle, the
// byte is a command; mode, address and data write take operand bytes in the
// beats that follow, and every operand byte is data even if it looks like a
// command. Unknown command bytes change nothing but still give a result.
// Output channel (out_valid/out_ready): exactly one result beat per input
// beat, in order: an optional reply byte (tx_valid/tx_byte) and the levels of
// all driven pins after that byte.
// The result is registered: into the output register, or into the skid register while the receiver stalls.
// Throughput: one beat per cycle while the skid register is empty; decode is a single combinational pass from
// the state registers to the output register.
// Stall: a two-entry output buffer (output register plus skid register)
// holds results; in_ready drops only once the skid entry is full, so one
// more beat is taken while the receiver stalls.
// Reset: synchronous, active high; the block returns to idle awaiting a
// command, address and data registers clear, pins low, test pin high, bus
// driven, and both output entries empty.
module byte_command_flash_pin_bridge (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   rx_byte,
  input  logic                         busy_pin,
  input  logic [7:0]                   bus_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         tx_valid,
  output logic [7:0]                   tx_byte,
  output logic                         write_enable_pin,
  output logic                         chip_enable_pin,
  output logic                         output_enable_pin,
  output logic                         test_pin,
  output logic                         reset_pulse,
  output logic [bcfpb_pkg::ADDR_W-1:0] latched_address,
  output logic [7:0]                   data_out,
  output logic                         data_drive
);
  import bcfpb_pkg::*;

  state_t  st;
  state_t  st_next;
  result_t res_now;
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  logic    in_fire;
  logic    out_free;

  bcfpb_decode u_decode (
    .st       (st),
    .rx_byte  (rx_byte),
    .busy_pin (busy_pin),
    .bus_in   (bus_in),
    .st_next  (st_next),
    .res      (res_now)
  );

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Command state: advance on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_IDLE;
      st.addr_cnt   <= '0;
      st.chain      <= '0;
      st.latch      <= '0;
      st.pins       <= 3'b000;
      st.indicator  <= 1'b1;
      st.bus_value  <= 8'h00;
      st.bus_driven <= 1'b1;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  // Output buffer control: refill from skid first, else from the new beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_fire) begin
        out_res <= res_now;
      end
    end else if (in_fire) begin
      skid_res <= res_now;
    end
  end

  assign tx_valid          = out_res.tx_valid;
  assign tx_byte           = out_res.tx_byte;
  assign write_enable_pin  = out_res.write_enable_pin;
  assign chip_enable_pin   = out_res.chip_enable_pin;
  assign output_enable_pin = out_res.output_enable_pin;
  assign test_pin          = out_res.test_pin;
  assign reset_pulse       = out_res.reset_pulse;
  assign latched_address   = out_res.latched_address;
  assign data_out          = out_res.data_out;
  assign data_drive        = out_res.data_drive;

endmodule

// ===== rtl/bcfpb_decode.sv =====
module bcfpb_decode (
  input  bcfpb_pkg::state_t  st,
  input  logic [7:0]         rx_byte,
  input  logic               busy_pin,
  input  logic [7:0]         bus_in,
  output bcfpb_pkg::state_t  st_next,
  output bcfpb_pkg::result_t res
);
  import bcfpb_pkg::*;

  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       reset_pulse;

  // Next state
  always_comb begin
    st_next = st;
    case (st.phase)
      PH_IDLE: begin
        case (rx_byte)
          OPC_INIT:   st_next.indicator = 1'b0;
          OPC_MODE:   st_next.phase = PH_MODE;
          OPC_ADDRESS: begin
            st_next.phase    = PH_ADDR;
            st_next.addr_cnt = '0;
          end
          OPC_WRITE: begin
            st_next.phase      = PH_DATAWR;
            st_next.bus_driven = 1'b1;
          end
          OPC_READ:   st_next.bus_driven = 1'b0;
          default:    ;
        endcase
      end
      PH_MODE: begin
        st_next.pins  = rx_byte[2:0];
        st_next.phase = PH_IDLE;
      end
      PH_DATAWR: begin
        st_next.bus_value = rx_byte;
        st_next.phase     = PH_IDLE;
      end
      PH_ADDR: begin
        st_next.chain = {st.chain[ADDR_W-9:0], rx_byte};
        if (st.addr_cnt == ADDR_LAST) begin
          st_next.latch = {st.chain[ADDR_W-9:0], rx_byte};
          st_next.phase = PH_IDLE;
        end else begin
          st_next.addr_cnt = st.addr_cnt + 1'b1;
        end
      end
      default: st_next.phase = PH_IDLE;
    endcase
  end

  // Reply and reset pulse
  always_comb begin
    tx_valid    = 1'b0;
    tx_byte     = 8'h00;
    reset_pulse = 1'b0;
    case (st.phase)
      PH_IDLE: begin
        case (rx_byte)
          OPC_INIT, OPC_STATUS: begin
            tx_valid = 1'b1;
            tx_byte  = REPLY_ACK;
          end
          OPC_RESET: begin
            tx_valid    = 1'b1;
            tx_byte     = REPLY_ACK;
            reset_pulse = 1'b1;
          end
          OPC_READY: begin
            tx_valid = 1'b1;
            tx_byte  = {7'd0, ~busy_pin};
          end
          OPC_READ: begin
            tx_valid = 1'b1;
            tx_byte  = bus_in;
          end
          default: ;
        endcase
      end
      PH_MODE, PH_DATAWR: begin
        tx_valid = 1'b1;
        tx_byte  = REPLY_ACK;
      end
      PH_ADDR: begin
        if (st.addr_cnt == ADDR_LAST) begin
          tx_valid = 1'b1;
          tx_byte  = REPLY_ACK;
        end
      end
      default: ;
    endcase
  end

  // Pin levels show the state after this beat
  assign res.tx_valid          = tx_valid;
  assign res.tx_byte           = tx_byte;
  assign res.write_enable_pin  = st_next.pins[0];
  assign res.chip_enable_pin   = st_next.pins[1];
  assign res.output_enable_pin = st_next.pins[2];
  assign res.test_pin          = st_next.indicator;
  assign res.reset_pulse       = reset_pulse;
  assign res.latched_address   = st_next.latch;
  assign res.data_out          = st_next.bus_value;
  assign res.data_drive        = st_next.bus_driven;

endmodule

// ===== rtl/bcfpb_checker.sv =====
module bcfpb_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       reset_pulse,
  input logic       data_drive
);
  import bcfpb_pkg::*;

  // Reset empties the output buffer
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(tx_valid))
    else $error("stalled result beat changed");

  // Reset pulse only comes with an ack
  a_pulse_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && reset_pulse |-> tx_valid && tx_byte == REPLY_ACK)
    else $error("reset pulse without ack");

  // No reply means an empty reply byte
  a_quiet_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> tx_byte == 8'h00)
    else $error("reply byte set without reply");

  // Read data can only be replied with the bus released
  a_read_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_valid && tx_byte != REPLY_ACK && tx_byte != 8'h00 &&
    tx_byte != 8'h01 |-> !data_drive)
    else $error("read data replied while driving the bus");

endmodule

bind byte_command_flash_pin_bridge bcfpb_checker u_bcfpb_checker (.*);

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bcfpb_pkg::*;

  // Track the bridge's command state and the pin levels it must show, and hold
  // one expected result per accepted host byte until the result beat arrives.
  class pin_level_board;
    phase_t            phase;
    int unsigned       addr_taken;
    logic [ADDR_W-1:0] chain;
    logic [ADDR_W-1:0] latch;
    logic [2:0]        pins;
    logic              indicator;
    logic [7:0]        bus_value;
    logic              bus_driven;
    result_t           pending_levels[$];
    int unsigned       mismatches;
    int unsigned       beats_seen;
    int unsigned       results_seen;
    int unsigned       replies_seen;
    int unsigned       latches_seen;
    int unsigned       ignored_seen;

    function new();
      phase      = PH_IDLE;
      addr_taken = 0;
      chain      = '0;
      latch      = '0;
      pins       = '0;
      indicator  = 1'b1;
      bus_value  = '0;
      bus_driven = 1'b1;
    endfunction

    // Advance the command state by one host byte and queue the levels it yields.
    function void take_host_byte(logic [7:0] rx, logic busy, logic [7:0] bus);
      result_t want;
      want = '0;
      beats_seen++;
      case (phase)
        PH_IDLE: begin
          case (rx)
            OPC_INIT: begin
              indicator     = 1'b0;
              want.tx_valid = 1'b1;
              want.tx_byte  = REPLY_ACK;
            end
            OPC_STATUS: begin
              want.tx_valid = 1'b1;
              want.tx_byte  = REPLY_ACK;
            end
            OPC_RESET: begin
              want.reset_pulse = 1'b1;
              want.tx_valid    = 1'b1;
              want.tx_byte     = REPLY_ACK;
            end
            OPC_MODE: phase = PH_MODE;
            OPC_READY: begin
              want.tx_valid = 1'b1;
              want.tx_byte  = {7'd0, ~busy};
            end
            OPC_ADDRESS: begin
              phase      = PH_ADDR;
              addr_taken = 0;
            end
            OPC_WRITE: begin
              bus_driven = 1'b1;
              phase      = PH_DATAWR;
            end
            OPC_READ: begin
              bus_driven    = 1'b0;
              want.tx_valid = 1'b1;
              want.tx_byte  = bus;
            end
            default: ignored_seen++;
          endcase
        end
        PH_MODE: begin
          pins          = rx[2:0];
          phase         = PH_IDLE;
          want.tx_valid = 1'b1;
          want.tx_byte  = REPLY_ACK;
        end
        PH_DATAWR: begin
          bus_value     = rx;
          phase         = PH_IDLE;
          want.tx_valid = 1'b1;
          want.tx_byte  = REPLY_ACK;
        end
        default: begin
          chain = {chain[ADDR_W-9:0], rx};
          addr_taken++;
          if (addr_taken >= ADDRESS_BYTES) begin
            latch         = chain;
            phase         = PH_IDLE;
            want.tx_valid = 1'b1;
            want.tx_byte  = REPLY_ACK;
            latches_seen++;
          end
        end
      endcase
      if (want.tx_valid) replies_seen++;
      want.write_enable_pin  = pins[0];
      want.chip_enable_pin   = pins[1];
      want.output_enable_pin = pins[2];
      want.test_pin          = indicator;
      want.latched_address   = latch;
      want.data_out          = bus_value;
      want.data_drive        = bus_driven;
      pending_levels.push_back(want);
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d, %s: expected 0x%0h, got 0x%0h",
                   results_seen, field, want, got);
      end
    endfunction

    // Match one result beat against the oldest expected levels.
    function void compare_levels(result_t got);
      result_t want;
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing expected, tx_byte 0x%0h", got.tx_byte);
        return;
      end
      want = pending_levels.pop_front();
      results_seen++;
      flag("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
      flag("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
      flag("write_enable_pin", 32'(want.write_enable_pin), 32'(got.write_enable_pin));
      flag("chip_enable_pin", 32'(want.chip_enable_pin), 32'(got.chip_enable_pin));
      flag("output_enable_pin", 32'(want.output_enable_pin),
           32'(got.output_enable_pin));
      flag("test_pin", 32'(want.test_pin), 32'(got.test_pin));
      flag("reset_pulse", 32'(want.reset_pulse), 32'(got.reset_pulse));
      flag("latched_address", 32'(want.latched_address), 32'(got.latched_address));
      flag("data_out", 32'(want.data_out), 32'(got.data_out));
      flag("data_drive", 32'(want.data_drive), 32'(got.data_drive));
    endfunction
  endclass

  localparam int unsigned RANDOM_BEATS = 1800;

  localparam logic [7:0] COMMAND_CODES [8] = '{
    OPC_INIT, OPC_STATUS, OPC_RESET, OPC_MODE,
    OPC_READY, OPC_ADDRESS, OPC_WRITE, OPC_READ
  };

  // Every input starts at a known level; hold reset from time zero.
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [7:0]        rx_byte   = '0;
  logic              busy_pin  = 1'b0;
  logic [7:0]        bus_in    = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              tx_valid;
  logic [7:0]        tx_byte;
  logic              write_enable_pin;
  logic              chip_enable_pin;
  logic              output_enable_pin;
  logic              test_pin;
  logic              reset_pulse;
  logic [ADDR_W-1:0] latched_address;
  logic [7:0]        data_out;
  logic              data_drive;

  // High while both sides run without idling.
  logic              steady    = 1'b0;

  int unsigned       beats_sent;
  int unsigned       ignored_sent;

  pin_level_board    levels = new();

  byte_command_flash_pin_bridge dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .busy_pin          (busy_pin),
    .bus_in            (bus_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .tx_valid          (tx_valid),
    .tx_byte           (tx_byte),
    .write_enable_pin  (write_enable_pin),
    .chip_enable_pin   (chip_enable_pin),
    .output_enable_pin (output_enable_pin),
    .test_pin          (test_pin),
    .reset_pulse       (reset_pulse),
    .latched_address   (latched_address),
    .data_out          (data_out),
    .data_drive        (data_drive)
  );

  always #5 clk = ~clk;

  // Stall the result side in about a fifth of the cycles, never while steady.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 21);
  end

  // Sample both channels at the edge; all drives land after it, so the values
  // seen here are the ones that decided each handshake.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        levels.take_host_byte(rx_byte, busy_pin, bus_in);
      if (out_valid && out_ready)
        levels.compare_levels(result_t'({tx_valid, tx_byte, write_enable_pin,
                                         chip_enable_pin, output_enable_pin,
                                         test_pin, reset_pulse, latched_address,
                                         data_out, data_drive}));
    end
  end

  // Present one host byte, idling first at random, and hold it until taken.
  task automatic send_beat(input logic [7:0] b, input logic busy, input logic [7:0] bus);
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    busy_pin <= busy;
    bus_in   <= bus;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_beat(b, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  function automatic logic is_command_code(logic [7:0] b);
    foreach (COMMAND_CODES[i])
      if (COMMAND_CODES[i] == b) return 1'b1;
    return 1'b0;
  endfunction

  // Operand bytes: mostly random, sometimes a command code that must be taken as data.
  function automatic logic [7:0] operand_byte();
    if ($urandom_range(0, 99) < 20)
      return COMMAND_CODES[3'($urandom_range(0, 7))];
    return 8'($urandom_range(0, 255));
  endfunction

  // Send one well-formed command with random content, or noise, or a cut-short
  // address sequence whose missing bytes are taken from what follows.
  task automatic random_sequence();
    int unsigned pick;
    logic [7:0]  code;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 15) begin
      do code = 8'($urandom_range(0, 255)); while (is_command_code(code));
      send_byte(code);
      ignored_sent++;
    end else begin
      case ($urandom_range(0, 7))
        0: send_byte(OPC_INIT);
        1: send_byte(OPC_STATUS);
        2: send_byte(OPC_RESET);
        3: begin
          send_byte(OPC_MODE);
          send_byte(operand_byte());
        end
        4: send_byte(OPC_READY);
        5: begin
          send_byte(OPC_ADDRESS);
          if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(0, ADDRESS_BYTES - 1)) send_byte(operand_byte());
          else
            repeat (ADDRESS_BYTES) send_byte(operand_byte());
        end
        6: begin
          send_byte(OPC_WRITE);
          send_byte(operand_byte());
        end
        default: send_byte(OPC_READ);
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: each command at least once, operand extremes, ready with and without
    // busy, read with both bus extremes, unknown codes at both ends of the byte.
    send_beat(OPC_INIT,    1'b0, 8'h00);
    send_beat(OPC_STATUS,  1'b1, 8'hFF);
    send_beat(OPC_RESET,   1'b0, 8'h00);
    send_beat(OPC_MODE,    1'b0, 8'h00);
    send_beat(8'hFF,       1'b1, 8'hFF);   // upper mode bits drop
    send_beat(OPC_MODE,    1'b0, 8'h00);
    send_beat(OPC_ADDRESS, 1'b0, 8'h00);   // command code as mode operand
    send_beat(OPC_READY,   1'b0, 8'h5A);
    send_beat(OPC_READY,   1'b1, 8'hA5);
    send_beat(OPC_ADDRESS, 1'b0, 8'h00);
    repeat (ADDRESS_BYTES) send_beat(8'hFF, 1'b1, 8'hFF);
    send_beat(OPC_WRITE,   1'b0, 8'h00);
    send_beat(OPC_READ,    1'b1, 8'h00);   // command code as write data
    send_beat(OPC_READ,    1'b0, 8'hFF);
    send_beat(OPC_READ,    1'b1, 8'h00);
    send_beat(8'h00,       1'b0, 8'h00);
    send_beat(8'hFF,       1'b1, 8'hFF);
    send_beat(OPC_WRITE,   1'b0, 8'h00);
    send_beat(8'h00,       1'b0, 8'h00);
    send_beat(OPC_ADDRESS, 1'b1, 8'hFF);
    send_beat(8'h00,       1'b0, 8'h00);
    send_beat(8'h01,       1'b1, 8'h80);
    send_beat(OPC_ADDRESS, 1'b0, 8'h01);   // command code as address byte

    // Random: run without any idling through a middle stretch.
    beats_sent   = 0;
    ignored_sent = 0;
    while (beats_sent - ignored_sent < RANDOM_BEATS) begin
      steady <= (beats_sent >= 700 && beats_sent < 1000);
      random_sequence();
    end
    in_valid <= 1'b0;
    steady   <= 1'b0;

    // Drain: let the last accepted beat reach the board, then wait for results.
    @(posedge clk);
    while (levels.pending_levels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d results from %0d host bytes: %0d replies, %0d address latches",
             levels.results_seen, levels.beats_seen, levels.replies_seen,
             levels.latches_seen);
    $display("%0d unknown command bytes ignored, %0d mismatches",
             levels.ignored_seen, levels.mismatches);
    if (levels.mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Drop the run if results stop coming.
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
